// ===== hw/rtl/rwc_pkg.sv =====
package rwc_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int TAPS       = 5;
  localparam int HALF       = TAPS / 2;
  localparam int COEF_BITS  = 12;
  localparam int CH_BITS    = 8;
  localparam int PIX_W      = 3 * CH_BITS;
  localparam int DIM_W      = 12;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 12;
  localparam int SEL_W      = 3;
  localparam int LINE_BITS  = (TAPS - 1) * PIX_W;
  localparam int PROD_W     = CH_BITS + 1 + COEF_BITS;
  localparam int SUM_W      = PROD_W + 4;
  localparam int ROW_REG_W  = TAPS * COEF_BITS;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 60;
  localparam int CH_MAX     = 255;
  localparam int DIM_MIN    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_FRAC_BITS    = 3'd2,
    REG_COEF_ROW_0   = 3'd3,
    REG_COEF_ROW_1   = 3'd4,
    REG_COEF_ROW_2   = 3'd5,
    REG_COEF_ROW_3   = 3'd6,
    REG_COEF_ROW_4   = 3'd7
  } reg_idx_t;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [SEL_W-1:0] sel_t;

  typedef struct packed {
    logic emit;
    logic last;
  } rwc_tag_t;

  typedef struct packed {
    pixel_t                pixel;
    logic [COL_W-1:0]      addr;
    sel_t [TAPS-1:0]       rsel;
    sel_t [TAPS-1:0]       csel;
    rwc_tag_t              tag;
  } rwc_s0_t;

  // window[k][l]: kernel row k, column l
  typedef pixel_t [TAPS-1:0][TAPS-1:0] window_t;
  typedef logic [TAPS-1:0][ROW_REG_W-1:0] coef_rows_t;

endpackage

// ===== hw/rtl/rwc_ram.sv =====
module rwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/rwc_window.sv =====
module rwc_window import rwc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     acc,
  input  rwc_s0_t  s0,
  output logic     win_valid,
  output rwc_tag_t win_tag,
  output window_t  window
);

  rwc_s0_t                          s1;
  logic                             s1_valid;
  logic [LINE_BITS-1:0]             rd_data;
  logic [LINE_BITS-1:0]             wr_data;
  pixel_t [TAPS-1:0]                rows;
  pixel_t [TAPS-1:0]                vec;
  pixel_t [TAPS-2:0][TAPS-1:0]      hist;
  pixel_t [TAPS-1:0][TAPS-1:0]      colv;
  window_t                          win_next;

  // one entry per column: the four rows above the current one
  rwc_ram #(.WIDTH(LINE_BITS), .DEPTH(MAX_WIDTH)) u_ram (
    .clk     (clk),
    .wr_en   (en && s1_valid),
    .wr_addr (s1.addr),
    .wr_data (wr_data),
    .rd_en   (acc),
    .rd_addr (s0.addr),
    .rd_data (rd_data)
  );

  always_comb begin
    rows[0] = s1.pixel;
    for (int i = 1; i < TAPS; i++) begin
      rows[i] = rd_data[(i-1)*PIX_W +: PIX_W];
    end
    wr_data = rows[TAPS-2:0];
    for (int k = 0; k < TAPS; k++) begin
      vec[k] = rows[0];
      for (int j = 0; j < TAPS; j++) begin
        if (s1.rsel[k] == SEL_W'(j)) begin
          vec[k] = rows[j];
        end
      end
    end
    colv[0] = vec;
    for (int d = 1; d < TAPS; d++) begin
      colv[d] = hist[d-1];
    end
    for (int l = 0; l < TAPS; l++) begin
      for (int k = 0; k < TAPS; k++) begin
        win_next[k][l] = colv[0][k];
        for (int d = 0; d < TAPS; d++) begin
          if (s1.csel[l] == SEL_W'(d)) begin
            win_next[k][l] = colv[d][k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      win_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= acc;
      win_valid <= s1_valid && s1.tag.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1      <= s0;
      window  <= win_next;
      win_tag <= s1.tag;
      if (s1_valid) begin
        hist <= {hist[TAPS-3:0], vec};
      end
    end
  end

endmodule

// ===== hw/rtl/rwc_mac.sv =====
module rwc_mac import rwc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               win_valid,
  input  rwc_tag_t           win_tag,
  input  window_t            window,
  input  coef_rows_t         coef_rows,
  input  logic [3:0]         frac_bits,
  output logic               out_valid,
  output logic [CH_BITS-1:0] out_red,
  output logic [CH_BITS-1:0] out_green,
  output logic [CH_BITS-1:0] out_blue,
  output logic               frame_last
);

  logic signed [PROD_W-1:0] prod [3][TAPS][TAPS];
  logic signed [SUM_W-1:0]  rsum [3][TAPS];
  logic signed [SUM_W-1:0]  tsum [3];
  logic signed [SUM_W-1:0]  rsum_next [3][TAPS];
  logic signed [SUM_W-1:0]  tsum_next [3];
  logic [CH_BITS-1:0]       res [3];
  logic                     va, vb, vc;
  logic                     la, lb, lc;

  function automatic logic [CH_BITS-1:0] finish(input logic signed [SUM_W-1:0] s,
                                                input logic [3:0] sh);
    logic signed [SUM_W-1:0] v;
    v = s >>> sh;
    if (s < 0) return '0;
    if (v > SUM_W'(CH_MAX)) return CH_BITS'(CH_MAX);
    return v[CH_BITS-1:0];
  endfunction

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      tsum_next[ch] = '0;
      for (int k = 0; k < TAPS; k++) begin
        rsum_next[ch][k] = '0;
        for (int l = 0; l < TAPS; l++) begin
          rsum_next[ch][k] = rsum_next[ch][k] + SUM_W'(prod[ch][k][l]);
        end
        tsum_next[ch] = tsum_next[ch] + rsum[ch][k];
      end
      res[ch] = finish(tsum[ch], frac_bits);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int k = 0; k < TAPS; k++) begin
          for (int l = 0; l < TAPS; l++) begin
            prod[ch][k][l] <= $signed({1'b0, window[k][l][ch*CH_BITS +: CH_BITS]})
                            * $signed(coef_rows[k][l*COEF_BITS +: COEF_BITS]);
          end
          rsum[ch][k] <= rsum_next[ch][k];
        end
        tsum[ch] <= tsum_next[ch];
      end
      la         <= win_tag.last;
      lb         <= la;
      lc         <= lb;
      out_red    <= res[0];
      out_green  <= res[1];
      out_blue   <= res[2];
      frame_last <= lc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va        <= win_valid;
      vb        <= va;
      vc        <= vb;
      out_valid <= vc;
    end
  end

endmodule

// ===== hw/rtl/rgb_window_convolution.sv =====
// Streaming 5x5 clamp-to-edge convolution of RGB pixels, one item per clock.
// Throughput: one item per cycle while the output is not stalled.
// A result passes registers s1, window, product, row sum, total and output;
// its item arrives 2*line_width+2 items after the pixel at the window centre.
// Reset (rst, synchronous): registers to defaults, counters to frame start;
// the line memory is not cleared, as no unwritten entry feeds the window.
module rgb_window_convolution import rwc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  req_type,
  input  logic [CH_BITS-1:0]    pixel_red,
  input  logic [CH_BITS-1:0]    pixel_green,
  input  logic [CH_BITS-1:0]    pixel_blue,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CH_BITS-1:0]    out_red,
  output logic [CH_BITS-1:0]    out_green,
  output logic [CH_BITS-1:0]    out_blue,
  output logic                  frame_last,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [DIM_W-1:0] line_width;
  logic [DIM_W-1:0] frame_height;
  logic [3:0]       frac_bits;
  coef_rows_t       coef_rows;

  // stream position: input pixel (in_row, in_col) and next output pixel
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic [COL_W-1:0] out_row;
  logic [COL_W-1:0] out_col;

  logic             en;
  logic             accept;
  logic [DIM_W-1:0] w, h;
  logic             emit, last;
  rwc_s0_t          s0;
  rwc_tag_t         win_tag;
  logic             win_valid;
  window_t          window;
  logic signed [13:0] t;

  // the whole pipeline advances unless a finished item waits on a stalled output
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign accept   = in_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= DIM_W'(1920);
      frame_height <= DIM_W'(1080);
      frac_bits    <= '0;
      // reset kernel: coefficient 1 in row 2, column 1, all others 0
      coef_rows    <= {ROW_REG_W'(0), ROW_REG_W'(0), ROW_REG_W'(4096),
                       ROW_REG_W'(0), ROW_REG_W'(0)};
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_LINE_WIDTH:   line_width   <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[DIM_W-1:0];
        REG_FRAC_BITS:    frac_bits    <= cfg_data[3:0];
        REG_COEF_ROW_0, REG_COEF_ROW_1, REG_COEF_ROW_2, REG_COEF_ROW_3, REG_COEF_ROW_4:
          coef_rows[3'(cfg_index - REG_COEF_ROW_0)] <= cfg_data[ROW_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp geometry into the supported range
  always_comb begin
    w = line_width;
    if (line_width < DIM_W'(DIM_MIN)) w = DIM_W'(DIM_MIN);
    else if (line_width > DIM_W'(MAX_WIDTH)) w = DIM_W'(MAX_WIDTH);
    h = frame_height;
    if (frame_height < DIM_W'(DIM_MIN)) h = DIM_W'(DIM_MIN);
    else if (frame_height > DIM_W'(MAX_HEIGHT)) h = DIM_W'(MAX_HEIGHT);
  end

  // an item emits once the window centre is 2 rows and 2 columns behind it
  assign emit = (in_row > ROW_W'(HALF)) || (in_row == ROW_W'(HALF) && in_col >= COL_W'(HALF));
  assign last = emit && ({1'b0, out_row} == h - 1'b1) && ({1'b0, out_col} == w - 1'b1);

  // Stage 0: pick, for each kernel row, which stored line gives the clamped
  // row, and for each kernel column, how far back in the column history the
  // clamped column sits. Rows past the frame end fall back to the last row.
  always_comb begin
    t = '0;
    s0.pixel    = (in_row < h && !req_type) ? {pixel_blue, pixel_green, pixel_red} : '0;
    s0.addr     = in_col;
    s0.tag.emit = emit;
    s0.tag.last = last;
    for (int k = 0; k < TAPS; k++) begin
      t = 14'(in_row) + 14'(k) - 14'(TAPS - 1);
      if (t < 0) s0.rsel[k] = SEL_W'(in_row);
      else if (t > 14'(h) - 14'sd1) s0.rsel[k] = SEL_W'(in_row - (h - 1'b1));
      else s0.rsel[k] = SEL_W'(TAPS - 1 - k);
    end
    for (int l = 0; l < TAPS; l++) begin
      t = 14'(out_col) + 14'(l) - 14'(HALF);
      if (t < 0) s0.csel[l] = SEL_W'(out_col + COL_W'(HALF));
      else if (t > 14'(w) - 14'sd1)
        s0.csel[l] = SEL_W'(14'(out_col) + 14'(HALF) - 14'(w) + 14'sd1);
      else s0.csel[l] = SEL_W'(TAPS - 1 - l);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
    end else if (accept) begin
      if (last) begin
        in_row  <= '0;
        in_col  <= '0;
        out_row <= '0;
        out_col <= '0;
      end else begin
        if ({1'b0, in_col} + 1'b1 >= w) begin
          in_col <= '0;
          in_row <= in_row + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
        if (emit) begin
          if ({1'b0, out_col} + 1'b1 >= w) begin
            out_col <= '0;
            out_row <= out_row + 1'b1;
          end else begin
            out_col <= out_col + 1'b1;
          end
        end
      end
    end
  end

  // Stage 1: line memory read-modify-write and window build
  rwc_window u_window (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .acc       (accept),
    .s0        (s0),
    .win_valid (win_valid),
    .win_tag   (win_tag),
    .window    (window)
  );

  // Stages 2 to 5: multiply, row sums, total, scale and saturate
  rwc_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .win_valid  (win_valid),
    .win_tag    (win_tag),
    .window     (window),
    .coef_rows  (coef_rows),
    .frac_bits  (frac_bits),
    .out_valid  (out_valid),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .frame_last (frame_last)
  );

  // frame end returns the input position to the origin
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> in_row == '0 && in_col == '0 && out_col == '0)
    else $error("position not cleared after frame end");

  // input column never runs past the row
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    accept |-> {1'b0, in_col} < w)
    else $error("input column beyond line width");

  // a waiting, stalled item blocks intake
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("intake open while output blocked");

endmodule

// ===== tb/sv/rgb_window_convolution_tb.sv =====
module rgb_window_convolution_tb;
  import rwc_pkg::*;

  localparam int RING_DEPTH = TAPS * MAX_WIDTH;
  localparam int IDLE_LIMIT = 40000;

  typedef struct {
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
    logic               last;
  } rgb_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  req_type = 1'b0;
  logic [CH_BITS-1:0]    pixel_red = '0;
  logic [CH_BITS-1:0]    pixel_green = '0;
  logic [CH_BITS-1:0]    pixel_blue = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CH_BITS-1:0]    out_red;
  logic [CH_BITS-1:0]    out_green;
  logic [CH_BITS-1:0]    out_blue;
  logic                  frame_last;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rgb_window_convolution dut (.*);

  always #1 clk = ~clk;

  // Snapshots taken mid-cycle: stable across the next rising edge.
  logic              in_stall_s, out_valid_s, frame_last_s;
  logic [PIX_W-1:0]  out_pix_s;
  always @(negedge clk) begin
    in_stall_s   = in_stall;
    out_valid_s  = out_valid;
    out_pix_s    = {out_blue, out_green, out_red};
    frame_last_s = frame_last;
  end

  // Mirror of the block's state and registers.
  logic [PIX_W-1:0]      row_ring [RING_DEPTH];
  logic [DIM_W-1:0]      width_reg, height_reg;
  logic [3:0]            shift_reg;
  logic [ROW_REG_W-1:0]  kernel_rows [TAPS];
  int unsigned           items_in_frame, pix_row, pix_col;
  rgb_result_t           pending_px[$];

  int  send_pct, recv_pct;
  int  hold_request;
  int  errors;
  int  quiet_cycles;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    return v < DIM_MIN ? DIM_MIN : (v > hi ? hi : v);
  endfunction

  function automatic logic [CH_BITS-1:0] scale_sat(int s);
    int v;
    if (s < 0) return '0;
    v = s >>> shift_reg;
    return v > CH_MAX ? CH_BITS'(CH_MAX) : v[CH_BITS-1:0];
  endfunction

  // Advance the mirror by one accepted item; queue the pixel it releases.
  task automatic predict_pixel(logic rt, logic [PIX_W-1:0] px_in);
    int unsigned w, h, total, lat, n, r, c, rr, cc;
    int          sr, sg, sb, cf;
    logic [PIX_W-1:0] px;
    rgb_result_t res;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    total = w * h;
    lat = HALF * w + HALF;
    n = items_in_frame;
    if (n < total) row_ring[n % RING_DEPTH] = rt ? '0 : px_in;
    items_in_frame = n + 1;
    if (n < lat) return;
    r = pix_row < h ? pix_row : h - 1;
    c = pix_col < w ? pix_col : w - 1;
    sr = 0; sg = 0; sb = 0;
    for (int k = 0; k < TAPS; k++) begin
      rr = (int'(r) + k < HALF) ? 0 : r + k - HALF;
      if (rr >= h) rr = h - 1;
      for (int l = 0; l < TAPS; l++) begin
        cc = (int'(c) + l < HALF) ? 0 : c + l - HALF;
        if (cc >= w) cc = w - 1;
        px = row_ring[(rr * w + cc) % RING_DEPTH];
        cf = $signed(kernel_rows[k][l*COEF_BITS +: COEF_BITS]);
        sr += int'(px[7:0]) * cf;
        sg += int'(px[15:8]) * cf;
        sb += int'(px[23:16]) * cf;
      end
    end
    res.red = scale_sat(sr);
    res.green = scale_sat(sg);
    res.blue = scale_sat(sb);
    res.last = (n + 1 >= total + lat);
    pending_px.push_back(res);
    if (res.last) begin
      items_in_frame = 0;
      pix_row = 0;
      pix_col = 0;
    end else begin
      pix_col++;
      if (pix_col >= w) begin
        pix_col = 0;
        pix_row = (pix_row + 1) & 11'h7FF;
      end
    end
  endtask

  // Compare each accepted output pixel with the oldest prediction.
  always @(posedge clk) begin
    rgb_result_t want;
    if (!rst && out_valid_s && !out_stall) begin
      if (pending_px.size() == 0) begin
        $display("%0t: unexpected pixel %h last %b", $time, out_pix_s, frame_last_s);
        errors++;
      end else begin
        want = pending_px.pop_front();
        if (want.red !== out_pix_s[7:0]) begin
          $display("%0t: out_red exp %h got %h", $time, want.red, out_pix_s[7:0]);
          errors++;
        end
        if (want.green !== out_pix_s[15:8]) begin
          $display("%0t: out_green exp %h got %h", $time, want.green, out_pix_s[15:8]);
          errors++;
        end
        if (want.blue !== out_pix_s[23:16]) begin
          $display("%0t: out_blue exp %h got %h", $time, want.blue, out_pix_s[23:16]);
          errors++;
        end
        if (want.last !== frame_last_s) begin
          $display("%0t: frame_last exp %b got %b", $time, want.last, frame_last_s);
          errors++;
        end
      end
    end
  end

  // Receiver: random stall, or a long hold-off counted down here.
  always @(posedge clk) begin
    int hold_left;
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall_s) || (out_valid_s && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("rgb_window_convolution_tb: done, errors");
      $finish;
    end
  end

  // Offer one item, with an optional gap first; hold it until accepted.
  task automatic send_item(logic rt, logic [PIX_W-1:0] px);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= rt;
    pixel_red   <= px[7:0];
    pixel_green <= px[15:8];
    pixel_blue  <= px[23:16];
    do @(posedge clk); while (in_stall_s);
    predict_pixel(rt, px);
  endtask

  // Drop valid and let every predicted pixel drain out.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_regs(int unsigned w, int unsigned h, int unsigned fb,
                          logic [ROW_REG_W-1:0] rows [TAPS]);
    logic [CFG_DATA_W-1:0] vals [8];
    vals[REG_LINE_WIDTH]   = CFG_DATA_W'(w);
    vals[REG_FRAME_HEIGHT] = CFG_DATA_W'(h);
    vals[REG_FRAC_BITS]    = CFG_DATA_W'(fb);
    for (int k = 0; k < TAPS; k++) vals[REG_COEF_ROW_0 + k] = rows[k];
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    width_reg  = DIM_W'(w);
    height_reg = DIM_W'(h);
    shift_reg  = 4'(fb);
    for (int k = 0; k < TAPS; k++) kernel_rows[k] = rows[k];
  endtask

  function automatic logic [ROW_REG_W-1:0] random_row(bit mild);
    logic [ROW_REG_W-1:0] row;
    int cf;
    if (!mild) return ROW_REG_W'({$urandom, $urandom});
    for (int l = 0; l < TAPS; l++) begin
      cf = int'($urandom_range(128)) - 64;
      row[l*COEF_BITS +: COEF_BITS] = cf[COEF_BITS-1:0];
    end
    return row;
  endfunction

  // One whole frame: pixels, then flush items. With noise, some flush ticks
  // fall in the pixel phase and some pixel items in the flush phase.
  task automatic send_frame(bit noisy, bit pause_midway);
    int unsigned w, h, total, lat;
    logic rt;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    total = w * h;
    lat = HALF * w + HALF;
    for (int unsigned i = 0; i < total + lat; i++) begin
      if (pause_midway && i == total / 2) begin
        in_valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge clk);
      end
      rt = (i >= total);
      if (noisy && $urandom_range(99) < 4) rt = ~rt;
      send_item(rt, PIX_W'($urandom));
    end
  endtask

  task automatic random_frame(bit pause_midway);
    logic [ROW_REG_W-1:0] rows [TAPS];
    bit mild;
    mild = ($urandom_range(3) != 0);
    for (int k = 0; k < TAPS; k++) rows[k] = random_row(mild);
    set_regs($urandom_range(12, 3), $urandom_range(8, 3),
             mild ? $urandom_range(7, 3) : $urandom_range(15), rows);
    send_frame(1'b1, pause_midway);
    drain();
  endtask

  // Smallest frame, extreme pixels and kernels, flush ticks in both phases.
  task automatic test_directed();
    logic [ROW_REG_W-1:0] rows [TAPS];
    logic [PIX_W-1:0] pix [9];
    for (int k = 0; k < TAPS; k++) rows[k] = '0;
    rows[HALF] = ROW_REG_W'(1) << (HALF * COEF_BITS);
    set_regs(3, 3, 0, rows);
    pix = '{24'h000000, 24'hFFFFFF, 24'h00FF00, 24'hFF00FF, 24'h0000FF,
            24'hFF0000, 24'hFFFFFF, 24'h000000, 24'h807F01};
    for (int i = 0; i < 9; i++) send_item(i == 4, pix[i]);
    for (int i = 0; i < 8; i++) send_item(i != 3, 24'hA5A5A5);
    drain();
    // Largest positive taps with the widest shift, then most negative taps.
    for (int k = 0; k < TAPS; k++) rows[k] = {TAPS{12'h7FF}};
    set_regs(3, 3, 15, rows);
    send_frame(1'b0, 1'b0);
    drain();
    for (int k = 0; k < TAPS; k++) rows[k] = {TAPS{12'h800}};
    set_regs(3, 3, 11, rows);
    send_frame(1'b0, 1'b0);
    drain();
  endtask

  // Geometry registers below their lower limit; values clamp up to 3.
  task automatic test_geometry_limits();
    logic [ROW_REG_W-1:0] rows [TAPS];
    for (int k = 0; k < TAPS; k++) rows[k] = random_row(1'b1);
    set_regs(0, 0, 4, rows);
    send_frame(1'b1, 1'b0);
    drain();
    set_regs(2, 1, 5, rows);
    send_frame(1'b0, 1'b0);
    drain();
    set_regs(1, 2, 6, rows);
    send_frame(1'b0, 1'b0);
    drain();
  endtask

  // Random frames over the three idling profiles.
  task automatic test_random_frames();
    int unsigned sent;
    int sp [3] = '{15, 82, 0};
    int rp [3] = '{82, 15, 0};
    for (int p = 0; p < 3; p++) begin
      send_pct = sp[p];
      recv_pct = rp[p];
      sent = 0;
      while (sent < 330) begin
        random_frame(1'b0);
        sent += clamp_dim(width_reg, MAX_WIDTH) * (clamp_dim(height_reg, MAX_HEIGHT) + 2) + 2;
      end
    end
  endtask

  // Hold the output off long enough to fill the pipe, then pause the sender
  // mid-frame until everything predicted has come out.
  task automatic test_back_pressure();
    send_pct = 0;
    recv_pct = 0;
    hold_request = 400;
    random_frame(1'b0);
    random_frame(1'b1);
  endtask

  initial begin
    errors = 0;
    quiet_cycles = 0;
    send_pct = 0;
    recv_pct = 0;
    hold_request = 0;
    width_reg = 1920;
    height_reg = 1080;
    shift_reg = 0;
    for (int k = 0; k < TAPS; k++) kernel_rows[k] = '0;
    kernel_rows[2] = 60'd4096;
    items_in_frame = 0;
    pix_row = 0;
    pix_col = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_geometry_limits();
    test_back_pressure();
    test_random_frames();

    drain();
    if (errors == 0) $display("rgb_window_convolution_tb: done, clean");
    else $display("rgb_window_convolution_tb: done, errors");
    $finish;
  end

endmodule

// ===== rgb_window_convolution.f =====
hw/rtl/rwc_pkg.sv
hw/rtl/rwc_ram.sv
hw/rtl/rwc_window.sv
hw/rtl/rwc_mac.sv
hw/rtl/rgb_window_convolution.sv
tb/sv/rgb_window_convolution_tb.sv
